// File: design/kscl_pkg.sv
// Package: widths, reset values and register indexes of the keypad scanner with code lock.
`default_nettype none

package kscl_pkg;

   localparam int MATRIX_SIDE   = 4;
   localparam int CODE_LENGTH   = 11;
   localparam int DIGIT_W       = 4;
   localparam int COUNT_W       = 4;
   localparam int KEY_W         = MATRIX_SIDE * MATRIX_SIDE;
   localparam int ROW_W         = $clog2(MATRIX_SIDE);
   localparam int SCAN_W        = 10;
   localparam int BLINK_W       = 14;
   localparam int CODE_W        = DIGIT_W * CODE_LENGTH;
   localparam int CSR_INDEX_W   = 2;

   localparam logic [SCAN_W-1:0]  SCAN_PERIOD_RST     = SCAN_W'(50);
   localparam logic [BLINK_W-1:0] BLINK_THRESHOLD_RST = BLINK_W'(100);
   localparam logic [CODE_W-1:0]  SECRET_CODE_RST     = CODE_W'(64'd1511833748262);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SCAN_PERIOD     = 2'd0,
      CSR_BLINK_THRESHOLD = 2'd1,
      CSR_SECRET_CODE     = 2'd2
   } csr_index_type;

   // Per-item state outputs of the scanner, handed to the key logic and result register
   typedef struct packed {
      logic [KEY_W-1:0]       key_map;
      logic [MATRIX_SIDE-1:0] row_drive;
   } scan_result_type;

endpackage

`default_nettype wire

// File: design/kscl_if.sv
// Interfaces: tick input channel, result channel and register write channel.
`default_nettype none

interface kscl_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [kscl_pkg::MATRIX_SIDE-1:0]      col_levels;

   modport source (output valid, output col_levels, input ready);
   modport sink   (input valid, input col_levels, output ready);
endinterface

interface kscl_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [kscl_pkg::MATRIX_SIDE-1:0]      row_drive;
   logic                                  led;
   logic                                  unlocked;
   logic [kscl_pkg::KEY_W-1:0]            key_map;

   modport source (output valid, output row_drive, output led, output unlocked,
                   output key_map, input ready);
   modport sink   (input valid, input row_drive, input led, input unlocked,
                   input key_map, output ready);
endinterface

interface kscl_csr_if;
   logic                                  valid;
   logic                                  ready;
   logic [kscl_pkg::CSR_INDEX_W-1:0]      index;
   logic [kscl_pkg::CODE_W-1:0]           data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: design/keypad_scan_code_lock_core.sv
// Top level: keypad scanner with code lock, tick register, state update and result register.
//
//   channel    dir   handshake        payload
//   req_chan   in    valid/ready      col_levels[3:0]
//   rsp_chan   out   valid/ready      row_drive[3:0], led, unlocked, key_map[15:0]
//   csr_chan   in    valid/ready      index[1:0], data[43:0]
//
// One tick item per cycle unless a result stalls; registers: tick register, result register.
// The whole per-tick update of scan, key and blink state sits between those two registers.
// A stalled result holds the pipe; a new tick is still taken while the tick register drains.
// Synchronous reset restores register defaults and clears control state; csr always ready.
`default_nettype none

module keypad_scan_code_lock_core (
   input  wire logic   clock,
   input  wire logic   reset,
   kscl_req_if.sink    req_chan,
   kscl_rsp_if.source  rsp_chan,
   kscl_csr_if.sink    csr_chan
);
   import kscl_pkg::*;

   logic [SCAN_W-1:0]      scan_period_ff;
   logic [BLINK_W-1:0]     blink_threshold_ff;
   logic [CODE_W-1:0]      secret_code_ff;

   logic                   in_valid_ff;
   logic [MATRIX_SIDE-1:0] in_col_ff;
   logic                   advance;

   logic                   out_valid_ff;
   logic [MATRIX_SIDE-1:0] out_row_ff;
   logic                   out_led_ff;
   logic                   out_unlocked_ff;
   logic [KEY_W-1:0]       out_key_ff;

   scan_result_type        scan_nxt;
   logic                   unlocked_nxt;
   logic                   phase_nxt;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_period_ff     <= SCAN_PERIOD_RST;
         blink_threshold_ff <= BLINK_THRESHOLD_RST;
         secret_code_ff     <= SECRET_CODE_RST;
      end else if (csr_chan.valid) begin
         case (csr_index_type'(csr_chan.index))
            CSR_SCAN_PERIOD:     scan_period_ff     <= csr_chan.data[SCAN_W-1:0];
            CSR_BLINK_THRESHOLD: blink_threshold_ff <= csr_chan.data[BLINK_W-1:0];
            CSR_SECRET_CODE:     secret_code_ff     <= csr_chan.data;
            default:             ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_col_ff <= req_chan.col_levels;
      end
   end

   kscl_scan u_scan (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .col_levels  (in_col_ff),
      .scan_period (scan_period_ff),
      .scan_nxt    (scan_nxt)
   );

   kscl_entry u_entry (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .key_map      (scan_nxt.key_map),
      .secret_code  (secret_code_ff),
      .unlocked_nxt (unlocked_nxt)
   );

   kscl_blink u_blink (
      .clock           (clock),
      .reset           (reset),
      .step            (advance),
      .blink_threshold (blink_threshold_ff),
      .phase_nxt       (phase_nxt)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_row_ff      <= scan_nxt.row_drive;
         out_led_ff      <= unlocked_nxt & phase_nxt;
         out_unlocked_ff <= unlocked_nxt;
         out_key_ff      <= scan_nxt.key_map;
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.row_drive = out_row_ff;
   assign rsp_chan.led       = out_led_ff;
   assign rsp_chan.unlocked  = out_unlocked_ff;
   assign rsp_chan.key_map   = out_key_ff;

endmodule

`default_nettype wire

// File: design/kscl_scan.sv
// Row scanner: scan timer, row drive and the 16-bit key map.
`default_nettype none

module kscl_scan (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             step,
   input  wire logic [kscl_pkg::MATRIX_SIDE-1:0] col_levels,
   input  wire logic [kscl_pkg::SCAN_W-1:0]      scan_period,
   output kscl_pkg::scan_result_type             scan_nxt
);
   import kscl_pkg::*;

   logic [SCAN_W-1:0]      elapsed_ff, elapsed_in, elapsed_inc;
   logic [KEY_W-1:0]       key_ff, key_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [MATRIX_SIDE-1:0] drive_ff, drive_in;
   logic                   scan_hit;

   always_comb begin
      elapsed_inc = (elapsed_ff != {SCAN_W{1'b1}}) ? elapsed_ff + 1'b1 : elapsed_ff;
      scan_hit    = (elapsed_inc >= scan_period);
      elapsed_in  = scan_hit ? '0 : elapsed_inc;
      key_in      = key_ff;
      row_in      = row_ff;
      drive_in    = drive_ff;
      if (scan_hit) begin
         // columns are active low: a low column marks the key pressed
         key_in[{row_ff, 2'b00} +: MATRIX_SIDE] = ~col_levels;
         row_in   = row_ff + 1'b1;
         drive_in = ~(MATRIX_SIDE'(1) << row_in);
      end
   end

   assign scan_nxt.key_map   = key_in;
   assign scan_nxt.row_drive = drive_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         key_ff     <= '0;
         row_ff     <= '0;
         drive_ff   <= '1;
      end else if (step) begin
         elapsed_ff <= elapsed_in;
         key_ff     <= key_in;
         row_ff     <= row_in;
         drive_ff   <= drive_in;
      end
   end

endmodule

`default_nettype wire

// File: design/kscl_entry.sv
// Key decode, digit entry buffer, code compare and unlock flag.
`default_nettype none

module kscl_entry (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        step,
   input  wire logic [kscl_pkg::KEY_W-1:0]  key_map,
   input  wire logic [kscl_pkg::CODE_W-1:0] secret_code,
   output logic                             unlocked_nxt
);
   import kscl_pkg::*;

   localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(CODE_LENGTH);
   localparam logic [COUNT_W-1:0] MAX_COUNT  = COUNT_W'(CODE_LENGTH + 2);

   typedef enum logic [2:0] {
      KEY_DIGIT,
      KEY_CLEAR,
      KEY_ENTER,
      KEY_SPARE,
      KEY_OTHER
   } key_kind_type;

   typedef struct packed {
      key_kind_type         kind;
      logic [DIGIT_W-1:0]   digit;
   } key_code_type;

   function automatic key_code_type decode_map(input logic [KEY_W-1:0] m);
      key_code_type k;
      k.kind  = KEY_DIGIT;
      k.digit = '0;
      case (m)
         16'h1000: k.digit = 4'd0;
         16'h0100: k.digit = 4'd1;
         16'h0200: k.digit = 4'd2;
         16'h0400: k.digit = 4'd3;
         16'h0010: k.digit = 4'd4;
         16'h0020: k.digit = 4'd5;
         16'h0040: k.digit = 4'd6;
         16'h0001: k.digit = 4'd7;
         16'h0002: k.digit = 4'd8;
         16'h0004: k.digit = 4'd9;
         16'h0008: k.kind  = KEY_CLEAR;
         16'h8000: k.kind  = KEY_ENTER;
         16'h0080, 16'h0800, 16'h2000, 16'h4000: k.kind = KEY_SPARE;
         default:  k.kind  = KEY_OTHER;
      endcase
      return k;
   endfunction

   logic [KEY_W-1:0]   prev_ff;
   logic [DIGIT_W-1:0] last_digit_ff, last_digit_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               unlock_ff, unlock_in;
   logic [DIGIT_W-1:0] buffer_ff [CODE_LENGTH];
   logic               buf_we;
   key_code_type       code;
   logic               fresh, code_match, store;

   always_comb begin
      code_match = 1'b1;
      for (int i = 0; i < CODE_LENGTH; i++) begin
         if (buffer_ff[i] != secret_code[DIGIT_W*i +: DIGIT_W]) code_match = 1'b0;
      end
   end

   always_comb begin
      code          = decode_map(key_map);
      fresh         = (key_map != '0) && (prev_ff == '0);
      last_digit_in = last_digit_ff;
      count_in      = count_ff;
      unlock_in     = unlock_ff;
      store         = 1'b0;
      if (fresh) begin
         case (code.kind)
            KEY_DIGIT: begin
               last_digit_in = code.digit;
               store         = 1'b1;
            end
            KEY_CLEAR: begin
               unlock_in = 1'b0;
               count_in  = '0;
            end
            KEY_ENTER: begin
               if (count_ff == FULL_COUNT) begin
                  if (code_match) unlock_in = 1'b1;
               end else begin
                  store = 1'b1;
               end
            end
            KEY_SPARE: store = 1'b0;
            default:   store = 1'b1;   // multi-key map repeats the last digit
         endcase
      end
      buf_we = store && (count_ff < FULL_COUNT);
      if (store && (count_ff < MAX_COUNT)) count_in = count_ff + 1'b1;
   end

   assign unlocked_nxt = unlock_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff       <= '0;
         last_digit_ff <= '0;
         count_ff      <= '0;
         unlock_ff     <= 1'b0;
      end else if (step) begin
         prev_ff       <= key_map;
         last_digit_ff <= last_digit_in;
         count_ff      <= count_in;
         unlock_ff     <= unlock_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step && buf_we) begin
         buffer_ff[count_ff[IDX_W-1:0]] <= last_digit_in;
      end
   end

endmodule

`default_nettype wire

// File: design/kscl_blink.sv
// Blink timer: saturating tick counter and LED phase.
`default_nettype none

module kscl_blink (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         step,
   input  wire logic [kscl_pkg::BLINK_W-1:0] blink_threshold,
   output logic                              phase_nxt
);
   import kscl_pkg::*;

   logic [BLINK_W-1:0] elapsed_ff, elapsed_in, elapsed_inc;
   logic               phase_ff, phase_in;
   logic               toggle;

   always_comb begin
      elapsed_inc = (elapsed_ff != {BLINK_W{1'b1}}) ? elapsed_ff + 1'b1 : elapsed_ff;
      toggle      = (elapsed_inc > blink_threshold);
      elapsed_in  = toggle ? '0 : elapsed_inc;
      phase_in    = phase_ff ^ toggle;
   end

   assign phase_nxt = phase_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         phase_ff   <= 1'b0;
      end else if (step) begin
         elapsed_ff <= elapsed_in;
         phase_ff   <= phase_in;
      end
   end

endmodule

`default_nettype wire

// File: design/kscl_checker.sv
// Port checker for the keypad scanner with code lock, bound to the top level.
`default_nettype none

module kscl_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [kscl_pkg::MATRIX_SIDE-1:0] rsp_row_drive,
   input wire logic                             rsp_led,
   input wire logic                             rsp_unlocked
);
   import kscl_pkg::*;

   // a result held under back-pressure stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   a_led_locked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_unlocked |-> !rsp_led)
      else $error("led lit while locked");

   // at most one row is ever driven low
   a_one_row: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $countones(rsp_row_drive) >= (MATRIX_SIDE - 1))
      else $error("more than one row driven");

endmodule

bind keypad_scan_code_lock_core kscl_checker u_kscl_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_row_drive (rsp_chan.row_drive),
   .rsp_led       (rsp_chan.led),
   .rsp_unlocked  (rsp_chan.unlocked)
);

`default_nettype wire
